// ===== rtl/dns_reply_address_extractor_defines.svh =====
// ----------------------------------------------------------------------------
// DNS reply address extractor - assertion macros
// Shared concurrent-assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef DNS_REPLY_ADDRESS_EXTRACTOR_DEFINES_SVH
`define DNS_REPLY_ADDRESS_EXTRACTOR_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define DRE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dre check failed");

// next-cycle implication, quiet while in reset
`define DRE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dre check failed");

// next-cycle implication that also covers the reset itself
`define DRE_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dre reset check failed");

`endif

// ===== rtl/dre_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS reply address extractor - package
// Shared types, status codes and header constants.
// ----------------------------------------------------------------------------
package dre_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] POS_MAX      = 16'hFFFF;
  localparam logic [15:0] FIRST_LABEL  = 16'd12;

  // header byte positions
  localparam logic [15:0] POS_ID_HI    = 16'd0;
  localparam logic [15:0] POS_ID_LO    = 16'd1;
  localparam logic [15:0] POS_FLAGS_HI = 16'd2;
  localparam logic [15:0] POS_FLAGS_LO = 16'd3;
  localparam logic [15:0] POS_AN_HI    = 16'd6;
  localparam logic [15:0] POS_AN_LO    = 16'd7;
  localparam logic [15:0] POS_HDR_END  = 16'd11;

  // offsets from start of answer name
  localparam logic [15:0] REL_RDLEN_HI = 16'd10;
  localparam logic [15:0] REL_RDLEN_LO = 16'd11;
  localparam logic [15:0] REL_ADDR_0   = 16'd12;
  localparam logic [15:0] REL_ADDR_3   = 16'd15;

  localparam logic [16:0] QFIXED_LEN   = 17'd5;  // root label + QTYPE + QCLASS
  localparam logic [15:0] RDLEN_IPV4   = 16'd4;

  localparam logic [7:0] QR_MASK    = 8'h80;
  localparam logic [7:0] RCODE_MASK = 8'h0F;
  localparam logic [7:0] PTR_MASK   = 8'hC0;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNCATED  = 3'd1,
    ST_NOT_RESP   = 3'd2,
    ST_ID_MISMATCH = 3'd3,
    ST_RCODE_ERR  = 3'd4,
    ST_NO_ANSWER  = 3'd5,
    ST_COMPRESSED = 3'd6,
    ST_BAD_RDLEN  = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'b0001,
    PH_QUESTION = 4'b0010,
    PH_ANSWER   = 4'b0100,
    PH_DONE     = 4'b1000
  } phase_t;

  // one classified word handed from front to back
  typedef struct packed {
    logic [7:0]  msg_byte;
    logic        is_last;
    logic [15:0] pos;
    logic        overflow;
  } word_t;

endpackage

// ===== rtl/dre_if.sv =====
// ----------------------------------------------------------------------------
// DNS reply address extractor - channel interfaces
// Valid/ready channels for message words and results.
// ----------------------------------------------------------------------------
interface dre_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       is_last;

  modport source (output valid, output msg_byte, output is_last, input ready);
  modport sink   (input valid, input msg_byte, input is_last, output ready);
endinterface

interface dre_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] ipv4_address;

  modport source (output valid, output status, output ipv4_address, input ready);
  modport sink   (input valid, input status, input ipv4_address, output ready);
endinterface

// ===== rtl/dre_front.sv =====
// ----------------------------------------------------------------------------
// DNS reply address extractor - front end
// Accepts message words and tags each with its byte position.
// ----------------------------------------------------------------------------
module dre_front (
  input  logic          clk,
  input  logic          rst,
  dre_byte_if.sink      rx,
  output logic          push_valid,
  input  logic          push_ready,
  output dre_pkg::word_t push_word
);
  import dre_pkg::*;

  logic [15:0] pos;
  logic        take;

  assign rx.ready   = push_ready;
  assign take       = rx.valid & push_ready;
  assign push_valid = rx.valid;

  always_comb begin
    push_word.msg_byte = rx.msg_byte;
    push_word.is_last  = rx.is_last;
    push_word.pos      = pos;
    push_word.overflow = (pos == POS_MAX);
  end

  // position counter; holds at max, restarts after the final word
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (take) begin
      if (rx.is_last) begin
        pos <= '0;
      end else if (pos != POS_MAX) begin
        pos <= pos + 16'd1;
      end
    end
  end

endmodule

// ===== rtl/dre_queue.sv =====
// ----------------------------------------------------------------------------
// DNS reply address extractor - word queue
// Small FIFO decoupling the front end from the parser.
// ----------------------------------------------------------------------------
module dre_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  dre_pkg::word_t push_word,
  output logic           pop_valid,
  input  logic           pop_ready,
  output dre_pkg::word_t pop_word
);
  import dre_pkg::*;

  word_t             entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_word   = entry[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/dre_back.sv =====
// ----------------------------------------------------------------------------
// DNS reply address extractor - parser back end
// Walks header, question and answer; registers one result per message.
// ----------------------------------------------------------------------------
module dre_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    expected_id,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  dre_pkg::word_t pop_word,
  dre_res_if.source      res
);
  import dre_pkg::*;

  phase_t      phase, phase_next;
  status_t     err, err_next;
  logic [3:0]  flags, flags_next;   // 0 id mismatch, 1 QR, 2 rcode, 3 ancount
  logic [7:0]  id_hi, id_hi_next;
  logic [15:0] nlab, nlab_next;
  logic [15:0] ans, ans_next;
  logic [7:0]  rdhi, rdhi_next;
  logic [31:0] addr, addr_next;

  logic [16:0] lab_sum;
  logic [16:0] ans_sum;
  logic [15:0] rel;
  logic [7:0]  b;
  logic [15:0] p;
  status_t     status_now;
  logic        take;

  // a final word needs the result register free
  assign pop_ready = ~pop_word.is_last | ~res.valid | res.ready;
  assign take      = pop_valid & pop_ready;
  assign b         = pop_word.msg_byte;
  assign p         = pop_word.pos;
  assign lab_sum   = {1'b0, p} + {9'd0, b} + 17'd1;
  assign ans_sum   = {1'b0, p} + QFIXED_LEN;
  assign rel       = p - ans;

  always_comb begin
    phase_next = phase;
    err_next   = err;
    flags_next = flags;
    id_hi_next = id_hi;
    nlab_next  = nlab;
    ans_next   = ans;
    rdhi_next  = rdhi;
    addr_next  = addr;

    if (pop_word.overflow) begin
      if (err == ST_OK) begin
        err_next = ST_TRUNCATED;
      end
    end else if (err == ST_OK) begin
      case (phase)
        PH_HEADER: begin
          case (p)
            POS_ID_HI: id_hi_next = b;
            POS_ID_LO: begin
              if ({id_hi, b} != expected_id) flags_next[0] = 1'b1;
            end
            POS_FLAGS_HI: begin
              if ((b & QR_MASK) != 8'd0) flags_next[1] = 1'b1;
            end
            POS_FLAGS_LO: begin
              if ((b & RCODE_MASK) != 8'd0) flags_next[2] = 1'b1;
            end
            POS_AN_HI, POS_AN_LO: begin
              if (b != 8'd0) flags_next[3] = 1'b1;
            end
            POS_HDR_END: begin
              if (!flags[1])      err_next   = ST_NOT_RESP;
              else if (flags[0])  err_next   = ST_ID_MISMATCH;
              else if (flags[2])  err_next   = ST_RCODE_ERR;
              else if (!flags[3]) err_next   = ST_NO_ANSWER;
              else                phase_next = PH_QUESTION;
            end
            default: ;
          endcase
        end
        PH_QUESTION: begin
          if (p == nlab) begin
            if (b == 8'd0) begin
              ans_next   = ans_sum[16] ? POS_MAX : ans_sum[15:0];
              phase_next = PH_ANSWER;
            end else if ((b & PTR_MASK) == PTR_MASK) begin
              err_next = ST_COMPRESSED;
            end else begin
              nlab_next = lab_sum[16] ? POS_MAX : lab_sum[15:0];
            end
          end
        end
        PH_ANSWER: begin
          if (p >= ans) begin
            if (rel == REL_RDLEN_HI) begin
              rdhi_next = b;
            end else if (rel == REL_RDLEN_LO) begin
              if ({rdhi, b} != RDLEN_IPV4) err_next = ST_BAD_RDLEN;
            end else if (rel inside {[REL_ADDR_0:REL_ADDR_3]}) begin
              addr_next = {addr[23:0], b};
              if (rel == REL_ADDR_3) phase_next = PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end

    if (err_next != ST_OK)        status_now = err_next;
    else if (phase_next != PH_DONE) status_now = ST_TRUNCATED;
    else                          status_now = ST_OK;
  end

  // parse state; cleared after every final word
  always_ff @(posedge clk) begin
    if (rst || (take && pop_word.is_last)) begin
      phase <= PH_HEADER;
      err   <= ST_OK;
      flags <= '0;
      id_hi <= '0;
      nlab  <= FIRST_LABEL;
      ans   <= '0;
      rdhi  <= '0;
      addr  <= '0;
    end else if (take) begin
      phase <= phase_next;
      err   <= err_next;
      flags <= flags_next;
      id_hi <= id_hi_next;
      nlab  <= nlab_next;
      ans   <= ans_next;
      rdhi  <= rdhi_next;
      addr  <= addr_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take && pop_word.is_last) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pop_word.is_last) begin
      res.status       <= status_now;
      res.ipv4_address <= (status_now == ST_OK) ? addr_next : 32'd0;
    end
  end

endmodule

// ===== rtl/dns_reply_address_extractor.sv =====
// DNS reply address extractor. Feed a received DNS message one byte word per
// cycle on rx, flagging the final byte with is_last; one result per message
// comes out on res: a status (0 ok, 1 truncated, 2 not a response, 3 ID
// mismatch, 4 RCODE error, 5 no answers, 6 compressed question name,
// 7 RDLENGTH not 4) and the first answer's IPv4 address, first octet in the
// top byte, zero unless the status is ok. Throughput is one byte per cycle
// while the queue has room, set by the single position compare and field
// capture in the parser. A final byte is written into the queue and then
// loaded by the parser into the result register, which raises res valid;
// the parser takes a final byte only while that register is free. A
// four-word queue sits between the byte-tagging front end and the parser,
// so rx keeps flowing while a result waits on res, until the next final
// byte reaches the parser and the queue fills behind it. expected_id is
// written through cfg_we / cfg_wdata and should only change between messages.
// ----------------------------------------------------------------------------
// DNS reply address extractor - top level
// Front end, word queue and parser, plus the expected-ID register.
// ----------------------------------------------------------------------------
module dns_reply_address_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  dre_byte_if.sink    rx,
  dre_res_if.source   res
);
  import dre_pkg::*;

  logic [15:0] expected_id;

  // front -> queue
  logic  push_valid;
  logic  push_ready;
  word_t push_word;

  // queue -> parser
  logic  pop_valid;
  logic  pop_ready;
  word_t pop_word;

  // config register; reset gives ID zero
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0;
    end else if (cfg_we) begin
      expected_id <= cfg_wdata;
    end
  end

  // tags each word with its position, saturating at the max length
  dre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  // decoupling queue; front stalls only when it is full
  dre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  // header checks, question skip, answer capture, result register
  dre_back u_back (
    .clk         (clk),
    .rst         (rst),
    .expected_id (expected_id),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_word    (pop_word),
    .res         (res)
  );

endmodule

// ===== rtl/dre_checker.sv =====
// ----------------------------------------------------------------------------
// DNS reply address extractor - port checker
// Watches the result port; bound onto the top level.
// ----------------------------------------------------------------------------
`include "dns_reply_address_extractor_defines.svh"

module dre_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_status,
  input logic [31:0] res_ipv4_address
);
  import dre_pkg::*;

  `DRE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
  `DRE_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_status) && $stable(res_ipv4_address))
  `DRE_ASSERT_NOW(a_addr_zero_on_err, res_valid && (res_status != ST_OK), res_ipv4_address == 32'd0)
  `DRE_ASSERT_RST(a_reset_idle, rst, !res_valid)

endmodule

bind dns_reply_address_extractor dre_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_status       (res.status),
  .res_ipv4_address (res.ipv4_address)
);
